@@ hdl/psev_pkg.sv @@
// Shared types and codes for the parametric spline evaluator.
package psev_pkg;

  // func codes carried in s_axis_tuser
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_POINT = 2'd1;
  localparam logic [1:0] FUNC_DERIV = 2'd2;

  // 1.0 in signed Q.30
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // request to the shared multiplier: floor(a*b / 2^16) or floor(a*b / 2^30)
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [33:0] b;
    logic               sh16;
  } mul_req_t;

  // request to the shared divider: shifts num_lo into rem0, one bit per step
  typedef struct packed {
    logic        start;
    logic [32:0] rem0;
    logic [31:0] num_lo;
    logic [32:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

endpackage

@@ hdl/parametric_spline_evaluator_core.sv @@
// Top level: knot store, interval search and Hermite evaluation sequencer.
//
//  channel   | dir | handshake                     | contents
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser func, tdata load/query word
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tuser status, tdata result_x/result_y
//  cfg       | in  | cfg_we                        | cfg_wdata knots_in_use
//
// A load word writes the knot tables and goes straight to the output register. An evaluate
// word runs the range check and search, the t divider when needed, then 14 multiplies on
// the shared multiplier; a derivative adds up to two divides on the shared divider.
// rst is synchronous; it clears control state, knots_in_use returns to 2, tables keep data.
// s_axis_tready is high only while idle; a finished word waits in the output register
// under m_axis_tready stall while the next input word is taken.
module parametric_spline_evaluator_core #(
  parameter int MAX_KNOTS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] entry_index, [39:8] knot_param, [71:40] knot_x, [103:72] knot_y,
  // [135:104] slope_x, [167:136] slope_y, [199:168] query_param
  input  logic [199:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] result_x, [63:32] result_y
  output logic [63:0]  m_axis_tdata,
  // [0] status
  output logic         m_axis_tuser,
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int NW = $clog2(MAX_KNOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK0, S_CHKN, S_CHKE, S_SRCH, S_SCMP, S_RDI, S_RDJ, S_CAPJ,
    S_TCHK, S_TDIV, S_MUL, S_MWAIT, S_FIN, S_DDIV, S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
      return $signed(32'h8000_0000);
    end
    return v[31:0];
  endfunction

  state_t             state;
  logic [8:0]         knots_in_use;
  logic [1:0]         func_r;
  logic signed [31:0] s_r;
  logic               flag_lo;
  logic [NW-1:0]      lo, len, idx_i;
  logic signed [31:0] p0, xv0, xv1, yv0, yv1, kx0, kx1, ky0, ky1;
  logic signed [32:0] ds, off;
  logic [30:0]        t;
  logic               c;
  logic [2:0]         op;
  logic signed [63:0] a, b, inner, tmp, acc;
  logic               neg;
  logic signed [31:0] rx, ry;
  logic               st;
  logic [31:0]        out_x, out_y;
  logic               out_st;

  // ---------------- knot tables ----------------
  logic          in_acc, ld_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rd_p_u, rd_x_u, rd_y_u, rd_kx_u, rd_ky_u;
  logic signed [31:0] rd_p;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign ld_we  = in_acc && (s_axis_tuser == psev_pkg::FUNC_LOAD)
                  && (32'(s_axis_tdata[7:0]) < MAX_KNOTS);
  assign waddr  = AW'(32'(s_axis_tdata[7:0]));
  assign rd_p   = rd_p_u;

  psev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram_p (
    .clk(clk), .we(ld_we), .waddr(waddr), .wdata(s_axis_tdata[39:8]),
    .raddr(raddr), .rdata(rd_p_u));
  psev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram_x (
    .clk(clk), .we(ld_we), .waddr(waddr), .wdata(s_axis_tdata[71:40]),
    .raddr(raddr), .rdata(rd_x_u));
  psev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram_y (
    .clk(clk), .we(ld_we), .waddr(waddr), .wdata(s_axis_tdata[103:72]),
    .raddr(raddr), .rdata(rd_y_u));
  psev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram_kx (
    .clk(clk), .we(ld_we), .waddr(waddr), .wdata(s_axis_tdata[135:104]),
    .raddr(raddr), .rdata(rd_kx_u));
  psev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram_ky (
    .clk(clk), .we(ld_we), .waddr(waddr), .wdata(s_axis_tdata[167:136]),
    .raddr(raddr), .rdata(rd_ky_u));

  // ---------------- search arithmetic ----------------
  logic [31:0]   kin32, n32;
  logic [NW-1:0] n, nm1, nm2, half, mid, i0, i_calc;

  assign kin32  = 32'(knots_in_use);
  assign n32    = (kin32 < 32'd2) ? 32'd2 :
                  (kin32 > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : kin32;
  assign n      = NW'(n32);
  assign nm1    = n - NW'(1);
  assign nm2    = n - NW'(2);
  assign half   = len >> 1;
  assign mid    = lo + half;
  assign i0     = (lo == '0) ? '0 : lo - NW'(1);
  assign i_calc = (i0 > nm2) ? nm2 : i0;

  // read address follows the state
  always_comb begin
    case (state)
      S_CHKN:  raddr = AW'(nm1);
      S_SRCH:  raddr = AW'(mid);
      S_RDI:   raddr = AW'(idx_i);
      S_RDJ:   raddr = AW'(idx_i + NW'(1));
      default: raddr = '0;
    endcase
  end

  // ---------------- coordinate operands ----------------
  logic               deriv;
  logic signed [31:0] r0_c, r1_c, k0_c, k1_c;
  logic signed [63:0] d_c;
  logic signed [33:0] ds_b, t_b, u_b, w_b;

  assign deriv = (func_r == psev_pkg::FUNC_DERIV);
  assign r0_c  = c ? yv0 : xv0;
  assign r1_c  = c ? yv1 : xv1;
  assign k0_c  = c ? ky0 : kx0;
  assign k1_c  = c ? ky1 : kx1;
  assign d_c   = 64'(r1_c) - 64'(r0_c);
  assign ds_b  = 34'(ds);
  assign t_b   = $signed({3'b000, t});
  assign u_b   = psev_pkg::ONE_Q30 - t_b;
  assign w_b   = psev_pkg::ONE_Q30 - (t_b <<< 1);

  // ---------------- shared multiplier ----------------
  psev_pkg::mul_req_t mreq;
  logic               mul_done;
  logic signed [63:0] mul_res;

  always_comb begin
    mreq.start = (state == S_MUL);
    mreq.sh16  = (op < 3'd2);
    case (op)
      3'd0: begin mreq.a = 64'(k0_c); mreq.b = ds_b; end
      3'd1: begin mreq.a = 64'(k1_c); mreq.b = ds_b; end
      3'd2: begin mreq.a = a;         mreq.b = u_b;  end
      3'd3: begin mreq.a = b;         mreq.b = t_b;  end
      3'd4: begin
        mreq.a = deriv ? inner : d_c;
        mreq.b = deriv ? w_b : t_b;
      end
      3'd5: begin mreq.a = deriv ? (a + b) : inner; mreq.b = t_b; end
      3'd6: begin mreq.a = tmp;       mreq.b = u_b;  end
      default: begin mreq.a = '0;     mreq.b = '0;   end
    endcase
  end

  psev_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mul_done), .res(mul_res));

  // ---------------- derivative magnitude and shared divider ----------------
  logic [63:0]        mag_full;
  logic [47:0]        mag;
  logic [31:0]        hi;
  logic               hi_ge, t_div_go;
  psev_pkg::div_req_t dreq;
  logic               div_done;
  logic [31:0]        quo, q_cl;
  logic signed [31:0] fin_val, ddiv_val;

  assign mag_full = acc[63] ? 64'(-acc) : 64'(acc);
  assign mag      = (mag_full > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : mag_full[47:0];
  assign hi       = mag[47:16];
  assign hi_ge    = $signed({2'b00, hi}) >= ds_b;
  assign t_div_go = (ds > 33'sd0) && (off > 33'sd0) && (off < ds);

  always_comb begin
    if (state == S_TCHK) begin
      dreq.start   = t_div_go;
      dreq.rem0    = off[32:0];
      dreq.num_lo  = 32'd0;
      dreq.steps   = 6'd30;
    end else begin
      dreq.start   = (state == S_FIN) && deriv && !hi_ge;
      dreq.rem0    = {1'b0, hi};
      dreq.num_lo  = {mag[15:0], 16'd0};
      dreq.steps   = 6'd32;
    end
    dreq.divisor = ds[32:0];
  end

  psev_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(div_done), .quo(quo));

  assign q_cl     = (quo > 32'h8000_0000) ? 32'h8000_0000 : quo;
  assign ddiv_val = neg ? $signed(-q_cl) : (q_cl[31] ? 32'sh7FFF_FFFF : $signed(q_cl));
  assign fin_val  = !deriv ? sat32(acc) :
                    (acc[63] ? $signed(32'h8000_0000) : 32'sh7FFF_FFFF);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      knots_in_use  <= 9'd2;
      m_axis_tvalid <= 1'b0;
      c             <= 1'b0;
      op            <= 3'd0;
    end else begin
      if (cfg_we) begin
        knots_in_use <= cfg_wdata;
      end
      // output word taken and no new word loaded this cycle
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            func_r <= s_axis_tuser;
            s_r    <= s_axis_tdata[199:168];
            rx     <= '0;
            ry     <= '0;
            st     <= 1'b0;
            if (s_axis_tuser == psev_pkg::FUNC_POINT ||
                s_axis_tuser == psev_pkg::FUNC_DERIV) begin
              state <= S_CHK0;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CHK0: state <= S_CHKN;
        S_CHKN: begin
          flag_lo <= s_r < rd_p;
          state   <= S_CHKE;
        end
        S_CHKE: begin
          if (flag_lo || s_r > rd_p) begin
            st    <= 1'b1;
            state <= S_DONE;
          end else begin
            lo    <= '0;
            len   <= n;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (len == '0) begin
            idx_i <= i_calc;
            state <= S_RDI;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (rd_p <= s_r) begin
            lo  <= mid + NW'(1);
            len <= len - half - NW'(1);
          end else begin
            len <= half;
          end
          state <= S_SRCH;
        end
        S_RDI: state <= S_RDJ;
        S_RDJ: begin
          p0    <= rd_p;
          xv0   <= rd_x_u;
          yv0   <= rd_y_u;
          kx0   <= rd_kx_u;
          ky0   <= rd_ky_u;
          state <= S_CAPJ;
        end
        S_CAPJ: begin
          xv1   <= rd_x_u;
          yv1   <= rd_y_u;
          kx1   <= rd_kx_u;
          ky1   <= rd_ky_u;
          ds    <= 33'(rd_p) - 33'(p0);
          off   <= 33'(s_r) - 33'(p0);
          state <= S_TCHK;
        end
        S_TCHK: begin
          c  <= 1'b0;
          op <= 3'd0;
          if (ds <= 33'sd0) begin
            st    <= 1'b1;
            state <= S_DONE;
          end else if (off <= 33'sd0) begin
            t     <= 31'd0;
            state <= S_MUL;
          end else if (off >= ds) begin
            t     <= 31'h4000_0000;
            state <= S_MUL;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            t     <= quo[30:0];
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            case (op)
              3'd0: a     <= mul_res - d_c;
              3'd1: b     <= mul_res - d_c;
              3'd2: inner <= mul_res;
              3'd3: inner <= inner - mul_res;
              3'd4: acc   <= (deriv ? d_c : 64'(r0_c)) + mul_res;
              3'd5: tmp   <= mul_res;
              3'd6: acc   <= deriv ? (acc - mul_res) : (acc + mul_res);
              default: acc <= acc;
            endcase
            if (op == 3'd6) begin
              state <= S_FIN;
            end else begin
              op    <= op + 3'd1;
              state <= S_MUL;
            end
          end
        end
        S_FIN: begin
          neg <= acc[63];
          if (deriv && !hi_ge) begin
            state <= S_DDIV;
          end else if (!c) begin
            rx    <= fin_val;
            c     <= 1'b1;
            op    <= 3'd0;
            state <= S_MUL;
          end else begin
            ry    <= fin_val;
            state <= S_DONE;
          end
        end
        S_DDIV: begin
          if (div_done) begin
            if (!c) begin
              rx    <= ddiv_val;
              c     <= 1'b1;
              op    <= 3'd0;
              state <= S_MUL;
            end else begin
              ry    <= ddiv_val;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_x         <= rx;
            out_y         <= ry;
            out_st        <= st;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_st;

  // ---------------- checks ----------------
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MWAIT) else $error("multiplier done outside wait state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_TDIV || state == S_DDIV))
    else $error("divider done outside wait state");

  a_status_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 64'd0)
    else $error("out-of-range word carries nonzero data");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE) else $error("accepted word did not start work");

endmodule

@@ hdl/psev_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/psev_mul.sv @@
// Shared multiplier: 64x34 signed product in a 33x34 low and a 32x34 high partial product, then shift.
module psev_mul (
  input  logic                clk,
  input  logic                rst,
  input  psev_pkg::mul_req_t  req,
  output logic                done,
  output logic signed [63:0]  res
);

  logic               busy;
  logic [1:0]         phase;
  logic signed [63:0] a_r;
  logic signed [33:0] b_r;
  logic               sh16_r;
  logic signed [66:0] prod;
  logic signed [97:0] acc;

  // low half, high half, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        phase  <= 2'd0;
        a_r    <= req.a;
        b_r    <= req.b;
        sh16_r <= req.sh16;
      end else if (busy) begin
        case (phase)
          2'd0: begin
            prod  <= $signed({1'b0, a_r[31:0]}) * b_r;
            phase <= 2'd1;
          end
          2'd1: begin
            acc   <= 98'(prod);
            prod  <= $signed(a_r[63:32]) * b_r;
            phase <= 2'd2;
          end
          2'd2: begin
            acc   <= acc + 98'($signed({prod, 32'd0}));
            busy  <= 1'b0;
            done  <= 1'b1;
            phase <= 2'd0;
          end
          default: begin
            busy  <= 1'b0;
            phase <= 2'd0;
          end
        endcase
      end
    end
  end

  // arithmetic shift gives the floor
  assign res = sh16_r ? 64'(acc >>> 16) : 64'(acc >>> 30);

endmodule

@@ hdl/psev_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module psev_div (
  input  logic               clk,
  input  logic               rst,
  input  psev_pkg::div_req_t req,
  output logic               done,
  output logic [31:0]        quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [31:0] num;
  logic [32:0] dvs;
  logic [33:0] sh;
  logic        fit;

  assign sh  = {rem, num[31]};
  assign fit = sh >= {1'b0, dvs};

  // one shift-compare-subtract step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= req.rem0;
        num  <= req.num_lo;
        dvs  <= req.divisor;
        quo  <= 32'd0;
      end else if (busy) begin
        rem <= fit ? 33'(sh - {1'b0, dvs}) : sh[32:0];
        quo <= {quo[30:0], fit};
        num <= {num[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
